/* src/rau_pkg.sv */
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package rau_pkg;

  localparam int DATA_W     = 32;
  localparam int DEN_W      = 31;
  localparam int ACT_W      = 3;
  localparam int CODE_W     = 2;
  localparam int WIDE_W     = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [ACT_W-1:0] ACT_ADD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SUB = 3'd1;
  localparam logic [ACT_W-1:0] ACT_MUL = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CMP = 3'd4;

  localparam logic [CODE_W-1:0] ORD_LT = 2'd0;
  localparam logic [CODE_W-1:0] ORD_EQ = 2'd1;
  localparam logic [CODE_W-1:0] ORD_GT = 2'd2;

  localparam logic [CODE_W-1:0] ST_OK   = 2'd0;
  localparam logic [CODE_W-1:0] ST_ZERO = 2'd1;
  localparam logic [CODE_W-1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_COMB, S_GCD_GO, S_GCD_WAIT,
    S_DIVN_GO, S_DIVN_WAIT, S_DIVD_GO, S_DIVD_WAIT, S_CHK, S_FIN
  } state_t;

  // handshake between sequencer and an iterative unit
  typedef struct packed {
    logic start;
  } unit_ctl_t;

endpackage
`default_nettype wire

/* src/rau_mul.sv */
// Registered 32x32 unsigned multiplier shared by the sequencer.
// Depends on rau_pkg.
`default_nettype none
module rau_mul (
  input  wire logic                           clk,
  input  wire logic [rau_pkg::DATA_W-1:0]     op_a,
  input  wire logic [rau_pkg::DATA_W-1:0]     op_b,
  output logic      [rau_pkg::WIDE_W-1:0]     prod_r
);
  import rau_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= WIDE_W'(op_a) * WIDE_W'(op_b);
  end
endmodule
`default_nettype wire

/* src/rau_gcd.sv */
// Binary (shift/subtract) gcd of two nonzero 64-bit magnitudes.
// Depends on rau_pkg. One compare/subtract or shift per cycle.
`default_nettype none
module rau_gcd (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rau_pkg::unit_ctl_t         ctl,
  input  wire logic [rau_pkg::WIDE_W-1:0] x_in,
  input  wire logic [rau_pkg::WIDE_W-1:0] y_in,
  output logic                            done_r,
  output logic      [rau_pkg::WIDE_W-1:0] g_r
);
  import rau_pkg::*;

  logic [WIDE_W-1:0] x_r, y_r;
  logic [6:0]        k_r;
  logic              busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        x_r    <= x_in;
        y_r    <= y_in;
        k_r    <= '0;
      end else if (busy_r) begin
        if (x_r == y_r) begin
          g_r    <= x_r << k_r[5:0];
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 7'd1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* src/rau_div.sv */
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// Depends on rau_pkg.
`default_nettype none
module rau_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire rau_pkg::unit_ctl_t         ctl,
  input  wire logic [rau_pkg::WIDE_W-1:0] dividend,
  input  wire logic [rau_pkg::WIDE_W-1:0] divisor,
  output logic                            done_r,
  output logic      [rau_pkg::WIDE_W-1:0] quo_r
);
  import rau_pkg::*;

  logic [WIDE_W:0]   rem_r;
  logic [WIDE_W-1:0] dsr_r;
  logic [6:0]        cnt_r;
  logic [WIDE_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem_r[WIDE_W-1:0], quo_r[WIDE_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        quo_r <= dividend;
        dsr_r <= divisor;
        rem_r <= '0;
        cnt_r <= 7'(WIDE_W);
      end else if (cnt_r != 7'd0) begin
        rem_r <= fits ? rem_sh - {1'b0, dsr_r} : rem_sh;
        quo_r <= {quo_r[WIDE_W-2:0], fits};
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) done_r <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit: add, subtract, multiply, divide or compare two
// 32-bit fractions, result reduced to lowest terms with a positive
// denominator. One item is in flight at a time; in_ready is low from the
// accepting transfer until the result is parked in the output stage. Items
// with zero denominators, divide by zero or undefined actions go straight to
// the finish state; compares run the multiply and combine steps; zero results
// skip the reduction; all others pass through the binary gcd unit and two
// passes of the bit-serial divider that scales numerator and denominator by
// the gcd. All products come from one registered 32x32 multiplier
// used three times.
// A finished result waits in the output register, so the next item is taken
// while the previous result is still unclaimed. Depends on rau_pkg, rau_mul,
// rau_gcd, rau_div.
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic        [rau_pkg::ACT_W-1:0]  in_action,
  input  wire logic signed [rau_pkg::DATA_W-1:0] in_a_num,
  input  wire logic signed [rau_pkg::DATA_W-1:0] in_a_den,
  input  wire logic signed [rau_pkg::DATA_W-1:0] in_b_num,
  input  wire logic signed [rau_pkg::DATA_W-1:0] in_b_den,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed      [rau_pkg::DATA_W-1:0] out_res_num,
  output logic             [rau_pkg::DEN_W-1:0]  out_res_den,
  output logic             [rau_pkg::CODE_W-1:0] out_order,
  output logic             [rau_pkg::CODE_W-1:0] out_status
);
  import rau_pkg::*;

  // largest allowed magnitude is LIM-1 (LIM for a negative numerator)
  localparam logic [WIDE_W-1:0] LIM = WIDE_W'(1) << (WORD_BITS - 1);

  state_t state_r, state_nxt;

  // captured item
  logic [ACT_W-1:0]  act_r;
  logic [DATA_W-1:0] an_r, ad_r, bn_r, bd_r;

  // sign-normalized operands
  logic              a_neg_r, b_neg_r;
  logic [DATA_W-1:0] a_mag_r, a_den_r, b_mag_r, b_den_r;

  // products: p = a*bden (or a*bmag), q = b*aden, d = aden*bden
  logic [WIDE_W-1:0] p_r, q_r, d_r;
  logic [1:0]        step_r;

  // unreduced / reduced result
  logic              r_neg_r;
  logic [WIDE_W-1:0] r_mag_r, r_den_r;

  // pending result
  logic [DATA_W-1:0] pend_num_r;
  logic [DEN_W-1:0]  pend_den_r;
  logic [CODE_W-1:0] pend_ord_r, pend_st_r;

  // output stage
  logic              out_valid_r;
  logic [DATA_W-1:0] out_num_r;
  logic [DEN_W-1:0]  out_den_r;
  logic [CODE_W-1:0] out_ord_r, out_st_r;

  logic in_xfer, out_free;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // ---- sign normalization ----
  logic signed [DATA_W:0] an_x, ad_x, bn_x, bd_x;
  logic signed [DATA_W:0] an_n, ad_n, bn_n, bd_n;
  always_comb begin
    an_x = {an_r[DATA_W-1], an_r};
    ad_x = {ad_r[DATA_W-1], ad_r};
    bn_x = {bn_r[DATA_W-1], bn_r};
    bd_x = {bd_r[DATA_W-1], bd_r};
    an_n = ad_x[DATA_W] ? -an_x : an_x;
    ad_n = ad_x[DATA_W] ? -ad_x : ad_x;
    bn_n = bd_x[DATA_W] ? -bn_x : bn_x;
    bd_n = bd_x[DATA_W] ? -bd_x : bd_x;
  end

  logic [DATA_W:0] an_abs, bn_abs;
  assign an_abs = an_n[DATA_W] ? DATA_W'(0) - an_n : an_n;
  assign bn_abs = bn_n[DATA_W] ? DATA_W'(0) - bn_n : bn_n;

  // ---- shared multiplier ----
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [WIDE_W-1:0] prod;
  always_comb begin
    case (step_r)
      2'd0:    begin mul_a = a_mag_r; mul_b = (act_r == ACT_MUL) ? b_mag_r : b_den_r; end
      2'd1:    begin mul_a = b_mag_r; mul_b = a_den_r; end
      default: begin mul_a = a_den_r; mul_b = b_den_r; end
    endcase
  end

  rau_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_r(prod));

  // ---- gcd and divider ----
  unit_ctl_t gcd_ctl, div_ctl;
  logic              gcd_done, div_done;
  logic [WIDE_W-1:0] g, quo, div_in;

  assign gcd_ctl.start = (state_r == S_GCD_GO);
  assign div_ctl.start = (state_r == S_DIVN_GO) || (state_r == S_DIVD_GO);
  assign div_in        = (state_r == S_DIVN_GO) ? r_mag_r : r_den_r;

  rau_gcd u_gcd (
    .clk(clk), .rst_n(rst_n), .ctl(gcd_ctl), .x_in(r_mag_r), .y_in(r_den_r),
    .done_r(gcd_done), .g_r(g)
  );

  rau_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .dividend(div_in), .divisor(g),
    .done_r(div_done), .quo_r(quo)
  );

  // ---- combine step (add-like sum or pass-through) ----
  logic              c_neg;
  logic [WIDE_W-1:0] c_mag, c_den;
  logic              add_like;
  assign add_like = (act_r == ACT_ADD) || (act_r == ACT_SUB) || (act_r == ACT_CMP);
  always_comb begin
    c_den = d_r;
    if (add_like) begin
      if (a_neg_r == b_neg_r) begin
        c_mag = p_r + q_r;
        c_neg = a_neg_r;
      end else if (p_r >= q_r) begin
        c_mag = p_r - q_r;
        c_neg = a_neg_r;
      end else begin
        c_mag = q_r - p_r;
        c_neg = b_neg_r;
      end
      if (c_mag == '0) c_neg = 1'b0;
    end else begin
      c_mag = p_r;
      c_neg = (a_neg_r != b_neg_r) && (p_r != '0);
      if (act_r == ACT_DIV) c_den = q_r;
    end
  end

  // overflow test on the reduced value
  logic ovf;
  logic [WIDE_W-1:0] neg_num;
  assign ovf = (r_den_r > LIM - 1) ||
               (r_neg_r ? (r_mag_r > LIM) : (r_mag_r > LIM - 1));
  assign neg_num = WIDE_W'(0) - r_mag_r;

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_xfer) state_nxt = S_PREP;
      S_PREP: begin
        if (ad_r == '0 || bd_r == '0) state_nxt = S_FIN;
        else if (act_r > ACT_CMP)    state_nxt = S_FIN;
        else if (act_r == ACT_DIV && bn_r == '0) state_nxt = S_FIN;
        else                         state_nxt = S_MUL;
      end
      S_MUL:       if (step_r == 2'd3) state_nxt = S_COMB;
      S_COMB: begin
        if (act_r == ACT_CMP)   state_nxt = S_FIN;
        else if (c_mag == '0)   state_nxt = S_CHK;
        else                    state_nxt = S_GCD_GO;
      end
      S_GCD_GO:    state_nxt = S_GCD_WAIT;
      S_GCD_WAIT:  if (gcd_done) state_nxt = S_DIVN_GO;
      S_DIVN_GO:   state_nxt = S_DIVN_WAIT;
      S_DIVN_WAIT: if (div_done) state_nxt = S_DIVD_GO;
      S_DIVD_GO:   state_nxt = S_DIVD_WAIT;
      S_DIVD_WAIT: if (div_done) state_nxt = S_CHK;
      S_CHK:       state_nxt = S_FIN;
      S_FIN:       if (out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          act_r <= in_action;
          an_r  <= in_a_num;
          ad_r  <= in_a_den;
          bn_r  <= in_b_num;
          bd_r  <= in_b_den;
        end
        step_r <= 2'd0;
      end
      S_PREP: begin
        a_neg_r <= an_n[DATA_W];
        a_mag_r <= an_abs[DATA_W-1:0];
        a_den_r <= ad_n[DATA_W-1:0];
        b_mag_r <= bn_abs[DATA_W-1:0];
        b_den_r <= bd_n[DATA_W-1:0];
        // subtract and compare flip the sign of a nonzero b
        if ((act_r == ACT_SUB || act_r == ACT_CMP) && bn_abs != '0)
          b_neg_r <= !bn_n[DATA_W];
        else
          b_neg_r <= bn_n[DATA_W];
        pend_num_r <= '0;
        pend_den_r <= '0;
        pend_ord_r <= ORD_LT;
        if (ad_r == '0 || bd_r == '0 || (act_r == ACT_DIV && bn_r == '0))
          pend_st_r <= ST_ZERO;
        else
          pend_st_r <= ST_OK;
      end
      S_MUL: begin
        step_r <= step_r + 2'd1;
        case (step_r)
          2'd1:    p_r <= prod;
          2'd2:    q_r <= prod;
          2'd3:    d_r <= prod;
          default: ;
        endcase
      end
      S_COMB: begin
        r_neg_r <= c_neg;
        r_mag_r <= c_mag;
        r_den_r <= (c_mag == '0) ? WIDE_W'(1) : c_den;
        if (act_r == ACT_CMP)
          pend_ord_r <= (c_mag == '0) ? ORD_EQ : (c_neg ? ORD_LT : ORD_GT);
      end
      S_DIVN_WAIT: if (div_done) r_mag_r <= quo;
      S_DIVD_WAIT: if (div_done) r_den_r <= quo;
      S_CHK: begin
        if (ovf) begin
          pend_st_r <= ST_OVF;
        end else begin
          pend_num_r <= r_neg_r ? neg_num[DATA_W-1:0] : r_mag_r[DATA_W-1:0];
          pend_den_r <= r_den_r[DEN_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_num_r <= pend_num_r;
      out_den_r <= pend_den_r;
      out_ord_r <= pend_ord_r;
      out_st_r  <= pend_st_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_num = out_num_r;
  assign out_res_den = out_den_r;
  assign out_order   = out_ord_r;
  assign out_status  = out_st_r;
endmodule
`default_nettype wire

/* src/rau_checker.sv */
// Port-level checks for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit.
`default_nettype none
module rau_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [rau_pkg::DATA_W-1:0]  out_res_num,
  input wire logic [rau_pkg::DEN_W-1:0]   out_res_den,
  input wire logic [rau_pkg::CODE_W-1:0]  out_order,
  input wire logic [rau_pkg::CODE_W-1:0]  out_status
);
  import rau_pkg::*;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("block took a second item while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_res_num == '0 && out_res_den == '0 && out_order == ORD_LT)
    else $error("error result carries nonzero fields");

  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_order != 2'd3 && out_status != 2'd3)
    else $error("unused order or status code");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_res_num) && $stable(out_status))
    else $error("stalled result changed");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_res_num(out_res_num),
  .out_res_den(out_res_den), .out_order(out_order), .out_status(out_status)
);
`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for rational_arithmetic_unit: directed table, then random items.
// Each result is checked against its typed-in value or a built-in predictor. Depends on rau_pkg and the block.
`timescale 1ns / 1ps
module tb_top;
  import rau_pkg::*;

  localparam int                   LIMIT_CYCLES = 3_000_000;
  localparam int                   LONG_HOLD    = 3000;
  localparam int                   N_RANDOM     = 480;
  localparam longint unsigned      LIM          = 64'd1 << (WORD_BITS_DEF - 1);
  // actions with no defined operation
  localparam logic [ACT_W-1:0]     ACT_RSV_LO   = 3'd5;
  localparam logic [ACT_W-1:0]     ACT_RSV_HI   = 3'd7;

  typedef struct {
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] a_num, a_den, b_num, b_den;
  } op_t;

  typedef struct {
    logic signed [DATA_W-1:0] num;
    logic [DEN_W-1:0]         den;
    logic [CODE_W-1:0]        order;
    logic [CODE_W-1:0]        status;
  } rslt_t;

  // one directed row; fixed == 1 means the typed-in result is used
  typedef struct {
    op_t   op;
    bit    fixed;
    rslt_t res;
  } row_t;

  // sign-magnitude fraction, denominator positive
  typedef struct {
    bit              neg;
    longint unsigned mag;
    longint unsigned den;
  } frac_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [ACT_W-1:0]         in_action = '0;
  logic signed [DATA_W-1:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_res_num;
  logic [DEN_W-1:0]         out_res_den;
  logic [CODE_W-1:0]        out_order;
  logic [CODE_W-1:0]        out_status;

  rslt_t pending_q[$];      // results still owed by the block
  row_t  table_q[$];
  int    errors = 0;
  int    cycles = 0;
  bit    no_idle = 0;       // both sides run without gaps
  bit    long_hold = 0;     // receiver stalls once; LONG_HOLD gives the length

  rational_arithmetic_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_action(in_action),
    .in_a_num(in_a_num), .in_a_den(in_a_den), .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_order(out_order), .out_status(out_status)
  );

  always #5 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic frac_t to_frac(logic signed [DATA_W-1:0] n32, logic signed [DATA_W-1:0] d32);
    longint n, d;
    frac_t  f;
    n = n32;
    d = d32;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    f.neg = n < 0;
    f.mag = (n < 0) ? -n : n;
    f.den = d;
    return f;
  endfunction

  // exact sum; cross products stay below 2^63
  function automatic frac_t frac_sum(frac_t a, frac_t b);
    longint unsigned p, q;
    frac_t r;
    p = a.mag * b.den;
    q = b.mag * a.den;
    r.den = a.den * b.den;
    if (a.neg == b.neg) begin
      r.mag = p + q;
      r.neg = a.neg;
    end else if (p >= q) begin
      r.mag = p - q;
      r.neg = a.neg;
    end else begin
      r.mag = q - p;
      r.neg = b.neg;
    end
    if (r.mag == 0) r.neg = 0;
    return r;
  endfunction

  function automatic rslt_t reduce_fraction(op_t op);
    frac_t           a, b, r;
    rslt_t           z;
    longint unsigned x, y, t;
    longint          n;
    z = '{num: '0, den: '0, order: ORD_LT, status: ST_OK};
    if (op.a_den == 0 || op.b_den == 0) begin
      z.status = ST_ZERO;
      return z;
    end
    a = to_frac(op.a_num, op.a_den);
    b = to_frac(op.b_num, op.b_den);
    case (op.action)
      ACT_ADD: r = frac_sum(a, b);
      ACT_SUB: begin
        if (b.mag != 0) b.neg = !b.neg;
        r = frac_sum(a, b);
      end
      ACT_MUL: begin
        r.mag = a.mag * b.mag;
        r.den = a.den * b.den;
        r.neg = (a.neg != b.neg) && r.mag != 0;
      end
      ACT_DIV: begin
        if (b.mag == 0) begin
          z.status = ST_ZERO;
          return z;
        end
        r.mag = a.mag * b.den;
        r.den = a.den * b.mag;
        r.neg = (a.neg != b.neg) && r.mag != 0;
      end
      ACT_CMP: begin
        if (b.mag != 0) b.neg = !b.neg;
        r = frac_sum(a, b);
        z.order = (r.mag == 0) ? ORD_EQ : (r.neg ? ORD_LT : ORD_GT);
        return z;
      end
      default: return z;
    endcase
    if (r.mag == 0) begin
      r.den = 1;
    end else begin
      x = r.mag;
      y = r.den;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      r.mag = r.mag / x;
      r.den = r.den / x;
    end
    if (r.den > LIM - 1 || (r.neg ? r.mag > LIM : r.mag > LIM - 1)) begin
      z.status = ST_OVF;
      return z;
    end
    n = r.neg ? -longint'(r.mag) : longint'(r.mag);
    z.num = n[DATA_W-1:0];
    z.den = r.den[DEN_W-1:0];
    return z;
  endfunction

  // ------------------------------------------------------------------ sender
  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  // offer one item, wait for its transfer, then record what it owes
  task automatic send_op(op_t op, bit fixed, rslt_t res);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= op.action;
    in_a_num  <= op.a_num;
    in_a_den  <= op.a_den;
    in_b_num  <= op.b_num;
    in_b_den  <= op.b_den;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(fixed ? res : reduce_fraction(op));
  endtask

  task automatic add_row(logic [ACT_W-1:0] act, int an, int ad, int bn, int bd,
                         bit fixed, int rn, int rd, logic [CODE_W-1:0] ord,
                         logic [CODE_W-1:0] st);
    row_t w;
    w.op    = '{action: act, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    w.fixed = fixed;
    w.res   = '{num: rn, den: DEN_W'(rd), order: ord, status: st};
    table_q.push_back(w);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_word(bit allow_zero);
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0:       v = $urandom();
      1:       v = $signed($urandom_range(0, 40)) - 20;
      2:       v = $signed($urandom_range(0, 2000)) - 1000;
      default: begin
        v = DATA_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    if (!allow_zero && v == 0) v = 1;
    return v;
  endfunction

  function automatic op_t rand_op();
    op_t  op;
    int   k;
    k = $urandom_range(0, 99);
    op.action = (k < 95) ? ACT_W'($urandom_range(ACT_ADD, ACT_CMP))
                         : ACT_W'($urandom_range(ACT_RSV_LO, ACT_RSV_HI));
    op.a_num  = rand_word(1);
    op.b_num  = rand_word(1);
    op.a_den  = rand_word(0);
    op.b_den  = rand_word(0);
    // some broken items: zero denominator
    if ($urandom_range(0, 39) == 0) op.a_den = 0;
    if ($urandom_range(0, 39) == 0) op.b_den = 0;
    // shared factors so the reduction has work to do
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(2, 97);
      op.a_num = op.a_num % 20000 * k;
      op.b_den = op.b_den % 20000 * k;
      if (op.b_den == 0) op.b_den = k;
    end
    // equal values for compare and subtract
    if ($urandom_range(0, 9) == 0) begin
      op.b_num = op.a_num;
      op.b_den = op.a_den;
    end
    return op;
  endfunction

  // ---------------------------------------------------------------- receiver
  initial begin : receiver
    int    gap;
    rslt_t e;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 0;
      end
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result num=%0d den=%0d order=%0d status=%0d",
                 $time, out_res_num, out_res_den, out_order, out_status);
      end else begin
        e = pending_q.pop_front();
        if (out_res_num !== e.num) begin
          errors++;
          $display("%0t: res_num expected %0d got %0d", $time, e.num, out_res_num);
        end
        if (out_res_den !== e.den) begin
          errors++;
          $display("%0t: res_den expected %0d got %0d", $time, e.den, out_res_den);
        end
        if (out_order !== e.order) begin
          errors++;
          $display("%0t: order expected %0d got %0d", $time, e.order, out_order);
        end
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, e.status, out_status);
        end
      end
    end
  end

  // -------------------------------------------------------------------- main
  initial begin : main
    rslt_t none;
    none = '{num: '0, den: '0, order: ORD_LT, status: ST_OK};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero denominators and divide by zero give the error code
    add_row(ACT_ADD, 1, 0, 1, 1, 1, 0, 0, ORD_LT, ST_ZERO);
    add_row(ACT_CMP, 1, 1, 1, 0, 1, 0, 0, ORD_LT, ST_ZERO);
    add_row(ACT_DIV, 3, 4, 0, 7, 1, 0, 0, ORD_LT, ST_ZERO);
    add_row(ACT_DIV, 3, 4, 0, -7, 1, 0, 0, ORD_LT, ST_ZERO);
    // zero result is 0/1
    add_row(ACT_ADD, 0, 5, 0, 7, 1, 0, 1, ORD_LT, ST_OK);
    add_row(ACT_SUB, 3, 9, 1, 3, 1, 0, 1, ORD_LT, ST_OK);
    add_row(ACT_MUL, 0, -5, 7, 3, 1, 0, 1, ORD_LT, ST_OK);
    // extremes and overflow
    add_row(ACT_ADD, 32'h7fffffff, 1, 1, 1, 1, 0, 0, ORD_LT, ST_OVF);
    add_row(ACT_MUL, 32'h80000000, 1, 1, 1, 1, 32'h80000000, 1, ORD_LT, ST_OK);
    add_row(ACT_MUL, 32'h80000000, -1, 1, 1, 1, 0, 0, ORD_LT, ST_OVF);
    add_row(ACT_MUL, 1, 32'h80000000, 1, 1, 1, 0, 0, ORD_LT, ST_OVF);
    add_row(ACT_DIV, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
            1, 1, 1, ORD_LT, ST_OK);
    add_row(ACT_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0);
    add_row(ACT_ADD, -1, -1, -1, -1, 1, 2, 1, ORD_LT, ST_OK);
    // compare: less, equal, greater, with sign normalisation
    add_row(ACT_CMP, 1, 3, 1, 2, 1, 0, 0, ORD_LT, ST_OK);
    add_row(ACT_CMP, 2, 4, -1, -2, 1, 0, 0, ORD_EQ, ST_OK);
    add_row(ACT_CMP, 1, -3, -1, 2, 1, 0, 0, ORD_GT, ST_OK);
    add_row(ACT_CMP, 32'h80000000, 1, 32'h7fffffff, 1, 1, 0, 0, ORD_LT, ST_OK);
    // ordinary arithmetic, checked by the predictor
    add_row(ACT_ADD, 1, 6, 1, 3, 0, 0, 0, 0, 0);
    add_row(ACT_SUB, -7, 12, 5, -18, 0, 0, 0, 0, 0);
    add_row(ACT_MUL, 6, -35, -14, 9, 0, 0, 0, 0, 0);
    add_row(ACT_DIV, 4, 9, -8, 27, 0, 0, 0, 0, 0);
    // undefined actions give an all-zero result
    add_row(ACT_RSV_LO, 5, 3, 2, 7, 1, 0, 0, ORD_LT, ST_OK);
    add_row(ACT_RSV_HI, 5, 3, 2, 7, 1, 0, 0, ORD_LT, ST_OK);

    foreach (table_q[i]) send_op(table_q[i].op, table_q[i].fixed, table_q[i].res);

    // sender pauses until the block has drained
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      // phases: normal gaps, a gap-free stretch, one long receiver stall
      if (i == N_RANDOM / 3) no_idle = 1;
      if (i == N_RANDOM / 2) begin
        no_idle   = 0;
        long_hold = 1;
      end
      if (i == 2 * N_RANDOM / 3) begin
        in_valid <= 1'b0;
        wait (pending_q.size() == 0);
        @(posedge clk);
      end
      send_op(rand_op(), 0, none);
    end
    in_valid <= 1'b0;

    wait (pending_q.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
